// File: hw/rtl/keyboard_scancode_ring_buffer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard scancode ring buffer
// Shared helpers that wrap clocked implication checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_RING_BUFFER_MACROS_SVH
`define KEYBOARD_SCANCODE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KBSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KBSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/kbsr_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard scancode ring buffer package
// Sizes, opcodes, the scancode translation table and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kbsr_pkg;

    localparam int DEPTH  = 256;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 9;
    localparam int CODE_W = 9;
    localparam int KEYS   = 58;
    localparam int KEY_W  = $clog2(KEYS);

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [OCC_W-1:0]  t_occ;

    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_POP = 2'd1;
    localparam logic [1:0] OP_RAW = 2'd2;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_ACUTE = 2'd1;
    localparam logic [1:0] ACC_DIAER = 2'd2;

    localparam t_code KN = 9'h100;
    localparam t_code KD = 9'h101;

    localparam t_code CH_NEWLINE  = 9'h00A;
    localparam t_code CH_A        = 9'h061;
    localparam t_code CH_E        = 9'h065;
    localparam t_code CH_I        = 9'h069;
    localparam t_code CH_O        = 9'h06F;
    localparam t_code CH_U        = 9'h075;
    localparam t_code CH_Z        = 9'h07A;
    localparam t_code CH_ENYE     = 9'h0A4;
    localparam t_code CH_A_ACUTE  = 9'h0A0;
    localparam t_code CH_E_ACUTE  = 9'h082;
    localparam t_code CH_I_ACUTE  = 9'h0A1;
    localparam t_code CH_O_ACUTE  = 9'h0A2;
    localparam t_code CH_U_ACUTE  = 9'h0A3;
    localparam t_code CH_U_DIAER  = 9'h081;

    localparam t_code KEY_TABLE [0:3][0:KEYS-1] = '{
        '{KN, KN, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037, 9'h038,
          9'h039, 9'h030, 9'h027, 9'h0A8, 9'h008, 9'h009,
          9'h071, 9'h077, 9'h065, 9'h072, 9'h074, 9'h079, 9'h075, 9'h069, 9'h06F, 9'h070,
          KD, 9'h02B, 9'h00A, KN,
          9'h061, 9'h073, 9'h064, 9'h066, 9'h067, 9'h068, 9'h06A, 9'h06B, 9'h06C,
          9'h0A4, 9'h07B, 9'h023, KN, 9'h07D,
          9'h07A, 9'h078, 9'h063, 9'h076, 9'h062, 9'h06E, 9'h06D,
          9'h02C, 9'h02E, 9'h02D, KN, KN, KN, 9'h020},
        '{KN, KN, 9'h021, 9'h022, 9'h023, 9'h024, 9'h025, 9'h026, 9'h02F, 9'h028,
          9'h029, 9'h03D, 9'h03F, 9'h0AD, 9'h008, 9'h009,
          9'h051, 9'h057, 9'h045, 9'h052, 9'h054, 9'h059, 9'h055, 9'h049, 9'h04F, 9'h050,
          KD, 9'h02A, 9'h00A, KN,
          9'h041, 9'h053, 9'h044, 9'h046, 9'h047, 9'h048, 9'h04A, 9'h04B, 9'h04C,
          9'h0A5, 9'h05B, 9'h023, KN, 9'h05D,
          9'h05A, 9'h058, 9'h043, 9'h056, 9'h042, 9'h04E, 9'h04D,
          9'h03B, 9'h03A, 9'h05F, KN, KN, KN, 9'h020},
        '{KN, KN, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037, 9'h038,
          9'h039, 9'h030, 9'h02D, 9'h03D, 9'h008, 9'h009,
          9'h071, 9'h077, 9'h065, 9'h072, 9'h074, 9'h079, 9'h075, 9'h069, 9'h06F, 9'h070,
          9'h05B, 9'h05D, 9'h00A, KN,
          9'h061, 9'h073, 9'h064, 9'h066, 9'h067, 9'h068, 9'h06A, 9'h06B, 9'h06C,
          9'h03B, 9'h027, 9'h060, KN, 9'h05C,
          9'h07A, 9'h078, 9'h063, 9'h076, 9'h062, 9'h06E, 9'h06D,
          9'h02C, 9'h02E, 9'h02F, KN, KN, KN, 9'h020},
        '{KN, KN, 9'h021, 9'h040, 9'h023, 9'h024, 9'h025, 9'h05E, 9'h026, 9'h02A,
          9'h028, 9'h029, 9'h05F, 9'h02B, 9'h008, 9'h009,
          9'h051, 9'h057, 9'h045, 9'h052, 9'h054, 9'h059, 9'h055, 9'h049, 9'h04F, 9'h050,
          9'h07B, 9'h07D, 9'h00A, KN,
          9'h041, 9'h053, 9'h044, 9'h046, 9'h047, 9'h048, 9'h04A, 9'h04B, 9'h04C,
          9'h03A, 9'h022, 9'h07E, KN, 9'h07C,
          9'h05A, 9'h058, 9'h043, 9'h056, 9'h042, 9'h04E, 9'h04D,
          9'h03C, 9'h03E, 9'h03F, KN, KN, KN, 9'h020}
    };

    typedef struct packed {
        logic exec;
    } t_ctrl_cmd;

    function automatic t_code key_code(input logic [1:0] row, input logic [7:0] sc);
        t_code code;
        code = KN;
        if (sc < 8'(KEYS)) begin
            code = KEY_TABLE[row][sc[KEY_W-1:0]];
        end
        return code;
    endfunction

endpackage

// File: hw/rtl/keyboard_scancode_ring_buffer.sv
// Latency: a result word is offered in the cycle after its input word is accepted.
// The two-state controller holds each result until it is taken before accepting more.
// Reset is synchronous and active low: it resets the pointers and clears the count, accent and layout.
// The character store is not cleared; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// Keyboard scancode ring buffer
// Translates scancodes to characters, queues them and raw characters in a ring FIFO, and pops them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyboard_scancode_ring_buffer
    import kbsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_layout,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_scan_code,
    input  logic              i_shift_held,
    input  logic              i_caps_lock_on,
    input  logic [7:0]        i_raw_char,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_popped_char,
    output logic              o_popped_valid,
    output logic              o_stored,
    output logic              o_dropped_full,
    output logic [FILL_W-1:0] o_fill_level
);

    t_ctrl_cmd cmd;

    assign o_cfg_ready = 1'b1;

    kbsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    kbsr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_layout   (i_cfg_layout),
        .i_opcode       (i_opcode),
        .i_scan_code    (i_scan_code),
        .i_shift_held   (i_shift_held),
        .i_caps_lock_on (i_caps_lock_on),
        .i_raw_char     (i_raw_char),
        .o_popped_char  (o_popped_char),
        .o_popped_valid (o_popped_valid),
        .o_stored       (o_stored),
        .o_dropped_full (o_dropped_full),
        .o_fill_level   (o_fill_level)
    );

endmodule

// File: hw/rtl/kbsr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbsr_ram #(
    parameter int DATA_W = 8,
    parameter int WORDS  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(WORDS)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(WORDS)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [0:WORDS-1];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/kbsr_ctrl.sv
// ----------------------------------------------------------------------------
// Keyboard scancode ring buffer controller
// Two-state sequencer that takes one word and then holds its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbsr_ctrl
    import kbsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_OUT  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.exec  = (r_state == S_IDLE) && i_in_valid;

endmodule

// File: hw/rtl/kbsr_datapath.sv
// ----------------------------------------------------------------------------
// Keyboard scancode ring buffer datapath
// Scancode translation, dead-key accents, FIFO pointers and the character store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbsr_datapath
    import kbsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_layout,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_scan_code,
    input  logic              i_shift_held,
    input  logic              i_caps_lock_on,
    input  logic [7:0]        i_raw_char,
    output logic [7:0]        o_popped_char,
    output logic              o_popped_valid,
    output logic              o_stored,
    output logic              o_dropped_full,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam t_slot LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam t_occ  OCC_FULL  = OCC_W'(DEPTH);
    localparam t_occ  OCC_LAST  = OCC_W'(DEPTH - 1);

    logic       r_layout;
    t_slot      r_wr_slot;
    t_slot      r_rd_slot;
    t_occ       r_occ;
    logic [1:0] r_accent;
    logic       r_pvalid;
    logic       r_stored;
    logic       r_dropped;

    t_slot      n_wr_slot;
    t_slot      n_rd_slot;
    t_occ       n_occ;
    logic [1:0] n_accent;
    logic       n_pvalid;
    logic       n_stored;
    logic       n_dropped;

    t_code      base_code;
    t_code      letter_code;
    t_code      shift_code;
    logic       modifier;
    logic       is_letter;
    logic [7:0] key_char;
    logic       push;
    logic [7:0] push_data;
    t_slot      push_slot;
    logic       rd_en;
    logic [7:0] rd_data;

    assign modifier    = i_shift_held ^ i_caps_lock_on;
    assign base_code   = key_code({r_layout, 1'b0}, i_scan_code);
    assign letter_code = key_code({r_layout, modifier}, i_scan_code);
    assign shift_code  = key_code({r_layout, i_shift_held}, i_scan_code);
    assign is_letter   = ((base_code >= CH_A) && (base_code <= CH_Z)) || (base_code == CH_ENYE);
    assign push_slot   = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;

    always_comb begin
        key_char = shift_code[7:0];
        if (is_letter) begin
            key_char = letter_code[7:0];
            if (!modifier && (r_accent == ACC_ACUTE)) begin
                case (base_code)
                    CH_A: key_char = CH_A_ACUTE[7:0];
                    CH_E: key_char = CH_E_ACUTE[7:0];
                    CH_I: key_char = CH_I_ACUTE[7:0];
                    CH_O: key_char = CH_O_ACUTE[7:0];
                    CH_U: key_char = CH_U_ACUTE[7:0];
                    default: key_char = letter_code[7:0];
                endcase
            end else if (!modifier && (r_accent == ACC_DIAER) && (base_code == CH_U)) begin
                key_char = CH_U_DIAER[7:0];
            end
        end
    end

    always_comb begin
        n_wr_slot = r_wr_slot;
        n_rd_slot = r_rd_slot;
        n_occ     = r_occ;
        n_accent  = r_accent;
        n_pvalid  = r_pvalid;
        n_stored  = r_stored;
        n_dropped = r_dropped;
        push      = 1'b0;
        push_data = i_raw_char;
        rd_en     = 1'b0;
        if (i_cmd.exec) begin
            n_pvalid  = 1'b0;
            n_stored  = 1'b0;
            n_dropped = 1'b0;
            case (i_opcode)
                OP_KEY: begin
                    if (r_occ >= OCC_FULL) begin
                        n_dropped = (base_code != KN);
                    end else if ((base_code != CH_NEWLINE) && (r_occ == OCC_LAST)) begin
                        n_dropped = (base_code != KN);
                    end else if (base_code == KN) begin
                        n_dropped = 1'b0;
                    end else if (base_code == KD) begin
                        n_accent = i_shift_held ? ACC_DIAER : ACC_ACUTE;
                    end else begin
                        push      = 1'b1;
                        push_data = key_char;
                        n_stored  = 1'b1;
                        if (is_letter) begin
                            n_accent = ACC_NONE;
                        end
                    end
                end
                OP_POP: begin
                    if (r_occ != '0) begin
                        rd_en     = 1'b1;
                        n_pvalid  = 1'b1;
                        n_occ     = r_occ - 1'b1;
                        n_rd_slot = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;
                    end
                end
                OP_RAW: begin
                    if (r_occ >= OCC_FULL) begin
                        n_dropped = 1'b1;
                    end else begin
                        push     = 1'b1;
                        n_stored = 1'b1;
                    end
                end
                default: begin
                    n_pvalid = 1'b0;
                end
            endcase
            if (push) begin
                n_wr_slot = push_slot;
                n_occ     = r_occ + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout  <= 1'b0;
            r_wr_slot <= LAST_SLOT;
            r_rd_slot <= '0;
            r_occ     <= '0;
            r_accent  <= ACC_NONE;
        end else begin
            if (i_cfg_we) begin
                r_layout <= i_cfg_layout;
            end
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_occ     <= n_occ;
            r_accent  <= n_accent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pvalid  <= n_pvalid;
        r_stored  <= n_stored;
        r_dropped <= n_dropped;
    end

    kbsr_ram #(
        .DATA_W (8),
        .WORDS  (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (push_slot),
        .i_wr_data (push_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (rd_data)
    );

    assign o_popped_char  = r_pvalid ? rd_data : 8'h00;
    assign o_popped_valid = r_pvalid;
    assign o_stored       = r_stored;
    assign o_dropped_full = r_dropped;
    assign o_fill_level   = FILL_W'(r_occ);

endmodule

// File: hw/rtl/kbsr_checker.sv
// ----------------------------------------------------------------------------
// Keyboard scancode ring buffer checker
// Port-level checks on result flags and pacing, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keyboard_scancode_ring_buffer_macros.svh"

module kbsr_checker
    import kbsr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_stall,
    input logic              i_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        i_popped_char,
    input logic              i_popped_valid,
    input logic              i_stored,
    input logic              i_dropped_full,
    input logic [FILL_W-1:0] i_fill_level
);

    `KBSR_ASSERT_SAME(a_flags_exclusive, i_clk, i_rst_n,
        i_out_valid && i_popped_valid, !i_stored && !i_dropped_full,
        "Pop result also reports a store or a drop.")
    `KBSR_ASSERT_SAME(a_stored_not_empty, i_clk, i_rst_n,
        i_out_valid && i_stored, i_fill_level != '0,
        "A stored word left the FIFO empty.")
    `KBSR_ASSERT_SAME(a_empty_pop_zero, i_clk, i_rst_n,
        i_out_valid && !i_popped_valid, i_popped_char == 8'h00,
        "Character is not zero without a popped word.")
    `KBSR_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n,
        i_in_valid && !i_in_stall, i_out_valid,
        "No result word after an accepted input word.")
    `KBSR_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n,
        i_out_valid && i_out_stall, i_out_valid && $stable(i_fill_level),
        "Stalled result word changed.")

endmodule

bind keyboard_scancode_ring_buffer kbsr_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_stall     (o_in_stall),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_popped_char  (o_popped_char),
    .i_popped_valid (o_popped_valid),
    .i_stored       (o_stored),
    .i_dropped_full (o_dropped_full),
    .i_fill_level   (o_fill_level)
);
